// File: rtl/khc_pkg.sv
// Package for the keyword hit counter: request codes, controller states and the
// command and status records that join the controller to the datapath.
// No dependencies.
package khc_pkg;

  localparam int unsigned DEF_MAX_KEYWORDS = 32;
  localparam int unsigned DEF_MAX_WORD     = 32;

  localparam int unsigned REQ_W   = 3;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned LINE_W  = 16;

  localparam logic [REQ_W-1:0] REQ_NEW_SET  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_KW_CHAR  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_KW_END   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TXT_CHAR = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LINE_END = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SET_END  = 3'd5;

  localparam logic RES_LINE = 1'b0;
  localparam logic RES_SET  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN_RD,
    S_LEN_CHK,
    S_CHR_RD,
    S_CHR_CHK,
    S_EMIT_LINE,
    S_EMIT_SET
  } ctrl_state_e;

  typedef struct packed {
    logic take;
    logic match_start;
    logic next_key;
    logic chr_start;
    logic chr_next;
    logic hit;
    logic close_tok;
    logic emit_line;
    logic emit_set;
  } khc_cmd_t;

  typedef struct packed {
    logic is_letter;
    logic can_match;
    logic len_eq;
    logic chr_eq;
    logic last_key;
    logic last_chr;
    logic out_free;
  } khc_sts_t;

endpackage

// File: rtl/khc_in_if.sv
// Input channel interface: request kind and character byte with valid/ready.
// Depends on khc_pkg.
interface khc_in_if import khc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output req_type, output char_code, input ready);
  modport sink (input valid, input req_type, input char_code, output ready);
endinterface

// File: rtl/khc_out_if.sv
// Result channel interface: per-line count or set maximum with valid/ready.
// Depends on khc_pkg.
interface khc_out_if import khc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [COUNT_W-1:0] hit_count;
  logic [LINE_W-1:0]  line_number;
  logic               keyword_dropped;

  modport source (output valid, output result_kind, output hit_count,
                  output line_number, output keyword_dropped, input ready);
  modport sink (input valid, input result_kind, input hit_count,
                input line_number, input keyword_dropped, output ready);
endinterface

// File: rtl/khc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module khc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/khc_ctrl.sv
// Controller state machine: accepts requests, sequences the keyword walk and result emits.
// Depends on khc_pkg.
module khc_ctrl import khc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [REQ_W-1:0] in_req_i,
  output logic             in_ready_o,
  input  khc_sts_t         sts_i,
  output khc_cmd_t         cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        line_end_q, line_end_d;
  ctrl_state_e after_match;

  assign in_ready_o  = (state_q == S_IDLE);
  assign after_match = line_end_q ? S_EMIT_LINE : S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      line_end_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      line_end_q <= line_end_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    line_end_d = line_end_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          line_end_d = (in_req_i == REQ_LINE_END);
          if (in_req_i == REQ_SET_END) begin
            state_d = S_EMIT_SET;
          end else if ((in_req_i == REQ_TXT_CHAR && !sts_i.is_letter) ||
                       in_req_i == REQ_LINE_END) begin
            if (sts_i.can_match) begin
              state_d = S_LEN_RD;
            end else if (in_req_i == REQ_LINE_END) begin
              state_d = S_EMIT_LINE;
            end
          end
        end
      end
      S_LEN_RD: state_d = S_LEN_CHK;
      S_LEN_CHK: begin
        if (sts_i.len_eq) begin
          state_d = S_CHR_RD;
        end else if (sts_i.last_key) begin
          state_d = after_match;
        end else begin
          state_d = S_LEN_RD;
        end
      end
      S_CHR_RD: state_d = S_CHR_CHK;
      S_CHR_CHK: begin
        if (!sts_i.chr_eq) begin
          state_d = sts_i.last_key ? after_match : S_LEN_RD;
        end else if (sts_i.last_chr) begin
          state_d = after_match;
        end else begin
          state_d = S_CHR_RD;
        end
      end
      S_EMIT_LINE: if (sts_i.out_free) state_d = S_IDLE;
      S_EMIT_SET: if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if ((in_req_i == REQ_TXT_CHAR && !sts_i.is_letter) ||
              in_req_i == REQ_LINE_END) begin
            if (sts_i.can_match) begin
              cmd_o.match_start = 1'b1;
            end else begin
              cmd_o.close_tok = 1'b1;
            end
          end
        end
      end
      S_LEN_CHK: begin
        if (sts_i.len_eq) begin
          cmd_o.chr_start = 1'b1;
        end else if (sts_i.last_key) begin
          cmd_o.close_tok = 1'b1;
        end else begin
          cmd_o.next_key = 1'b1;
        end
      end
      S_CHR_CHK: begin
        if (!sts_i.chr_eq) begin
          if (sts_i.last_key) begin
            cmd_o.close_tok = 1'b1;
          end else begin
            cmd_o.next_key = 1'b1;
          end
        end else if (sts_i.last_chr) begin
          cmd_o.hit       = 1'b1;
          cmd_o.close_tok = 1'b1;
        end else begin
          cmd_o.chr_next = 1'b1;
        end
      end
      S_EMIT_LINE: cmd_o.emit_line = sts_i.out_free;
      S_EMIT_SET: cmd_o.emit_set = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: rtl/khc_dp.sv
// Datapath: dictionary and token memories, counters, walk indices and the
// result register. Depends on khc_pkg and khc_ram.
module khc_dp import khc_pkg::*; #(
  parameter int unsigned MAX_KEYWORDS = DEF_MAX_KEYWORDS,
  parameter int unsigned MAX_WORD     = DEF_MAX_WORD
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [REQ_W-1:0]   in_req_i,
  input  logic [CHAR_W-1:0]  in_char_i,
  input  khc_cmd_t           cmd_i,
  output khc_sts_t           sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_kind_o,
  output logic [COUNT_W-1:0] out_count_o,
  output logic [LINE_W-1:0]  out_line_o,
  output logic               out_drop_o
);

  localparam int unsigned DICT_DEPTH = MAX_KEYWORDS * MAX_WORD;
  localparam int unsigned DA = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
  localparam int unsigned LA = (MAX_KEYWORDS > 1) ? $clog2(MAX_KEYWORDS) : 1;
  localparam int unsigned TW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int unsigned KW = $clog2(MAX_KEYWORDS + 1);
  localparam int unsigned EW = $clog2(MAX_WORD + 1);

  logic [KW-1:0] entries_q, entries_d;
  logic [EW-1:0] elen_q, elen_d;
  logic          eovf_q, eovf_d;
  logic [DA-1:0] wbase_q, wbase_d;
  logic [EW-1:0] tlen_q, tlen_d;
  logic          tovf_q, tovf_d;
  logic [COUNT_W-1:0] hits_q, hits_d, best_q, best_d;
  logic [LINE_W-1:0]  line_q, line_d;
  logic          drop_q, drop_d;
  logic [KW-1:0] k_q, k_d;
  logic [DA-1:0] rbase_q, rbase_d;
  logic [TW-1:0] j_q, j_d;
  logic          out_valid_q, out_valid_d;

  logic              full, upper, letter;
  logic              dict_we, len_we, tok_we;
  logic [CHAR_W-1:0] folded;
  logic [CHAR_W-1:0] dict_rdata, tok_rdata;
  logic [EW-1:0]     len_rdata;

  assign full   = (entries_q >= KW'(MAX_KEYWORDS));
  assign upper  = (in_char_i >= 8'h41) && (in_char_i <= 8'h5A);
  assign letter = upper || ((in_char_i >= 8'h61) && (in_char_i <= 8'h7A));
  assign folded = upper ? (in_char_i | 8'h20) : in_char_i;

  assign dict_we = cmd_i.take && (in_req_i == REQ_KW_CHAR) &&
                   (elen_q < EW'(MAX_WORD)) && !eovf_q && !full;
  assign len_we  = cmd_i.take && (in_req_i == REQ_KW_END) &&
                   ((elen_q != '0) || eovf_q) && !eovf_q && !full;
  assign tok_we  = cmd_i.take && (in_req_i == REQ_TXT_CHAR) && letter &&
                   (tlen_q < EW'(MAX_WORD));

  khc_ram #(.WIDTH(CHAR_W), .DEPTH(DICT_DEPTH)) u_dict_ram (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (wbase_q + DA'(elen_q)),
    .wdata_i (in_char_i),
    .raddr_i (rbase_q + DA'(j_q)),
    .rdata_o (dict_rdata)
  );

  khc_ram #(.WIDTH(EW), .DEPTH(MAX_KEYWORDS)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (LA'(entries_q)),
    .wdata_i (elen_q),
    .raddr_i (LA'(k_q)),
    .rdata_o (len_rdata)
  );

  khc_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_WORD)) u_tok_ram (
    .clk_i   (clk_i),
    .we_i    (tok_we),
    .waddr_i (TW'(tlen_q)),
    .wdata_i (folded),
    .raddr_i (j_q),
    .rdata_o (tok_rdata)
  );

  assign sts_o.is_letter = letter;
  assign sts_o.can_match = (tlen_q != '0) && !tovf_q && (entries_q != '0);
  assign sts_o.len_eq    = (len_rdata == tlen_q);
  assign sts_o.chr_eq    = (dict_rdata == tok_rdata);
  assign sts_o.last_key  = ((k_q + KW'(1)) == entries_q);
  assign sts_o.last_chr  = ((EW'(j_q) + EW'(1)) == tlen_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    entries_d   = entries_q;
    elen_d      = elen_q;
    eovf_d      = eovf_q;
    wbase_d     = wbase_q;
    tlen_d      = tlen_q;
    tovf_d      = tovf_q;
    hits_d      = hits_q;
    best_d      = best_q;
    line_d      = line_q;
    drop_d      = drop_q;
    k_d         = k_q;
    rbase_d     = rbase_q;
    j_d         = j_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.take) begin
      case (in_req_i)
        REQ_KW_CHAR: begin
          if (dict_we) begin
            elen_d = elen_q + EW'(1);
          end else if (elen_q >= EW'(MAX_WORD)) begin
            eovf_d = 1'b1;
          end else begin
            elen_d = elen_q + EW'(1);
          end
        end
        REQ_KW_END: begin
          if ((elen_q != '0) || eovf_q) begin
            if (eovf_q || full) begin
              drop_d = 1'b1;
            end else begin
              entries_d = entries_q + KW'(1);
              wbase_d   = wbase_q + DA'(MAX_WORD);
            end
            elen_d = '0;
            eovf_d = 1'b0;
          end
        end
        REQ_TXT_CHAR: begin
          if (tok_we) begin
            tlen_d = tlen_q + EW'(1);
          end else if (letter) begin
            tovf_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.match_start) begin
      k_d     = '0;
      rbase_d = '0;
    end
    if (cmd_i.next_key) begin
      k_d     = k_q + KW'(1);
      rbase_d = rbase_q + DA'(MAX_WORD);
    end
    if (cmd_i.chr_start) j_d = '0;
    if (cmd_i.chr_next) j_d = j_q + TW'(1);
    if (cmd_i.hit && (hits_q != '1)) hits_d = hits_q + COUNT_W'(1);
    if (cmd_i.close_tok) begin
      tlen_d = '0;
      tovf_d = 1'b0;
    end

    if (cmd_i.emit_line) begin
      out_valid_d = 1'b1;
      if (hits_q > best_q) best_d = hits_q;
      if (line_q != '1) line_d = line_q + LINE_W'(1);
      hits_d = '0;
    end

    if ((cmd_i.take && (in_req_i == REQ_NEW_SET)) || cmd_i.emit_set) begin
      entries_d = '0;
      elen_d    = '0;
      eovf_d    = 1'b0;
      wbase_d   = '0;
      tlen_d    = '0;
      tovf_d    = 1'b0;
      hits_d    = '0;
      best_d    = '0;
      line_d    = '0;
      drop_d    = 1'b0;
    end
    if (cmd_i.emit_set) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q   <= '0;
      elen_q      <= '0;
      eovf_q      <= 1'b0;
      wbase_q     <= '0;
      tlen_q      <= '0;
      tovf_q      <= 1'b0;
      hits_q      <= '0;
      best_q      <= '0;
      line_q      <= '0;
      drop_q      <= 1'b0;
      k_q         <= '0;
      rbase_q     <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      entries_q   <= entries_d;
      elen_q      <= elen_d;
      eovf_q      <= eovf_d;
      wbase_q     <= wbase_d;
      tlen_q      <= tlen_d;
      tovf_q      <= tovf_d;
      hits_q      <= hits_d;
      best_q      <= best_d;
      line_q      <= line_d;
      drop_q      <= drop_d;
      k_q         <= k_d;
      rbase_q     <= rbase_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_line || cmd_i.emit_set) begin
      out_kind_o  <= cmd_i.emit_set ? RES_SET : RES_LINE;
      out_count_o <= cmd_i.emit_set ? best_q : hits_q;
      out_line_o  <= line_q;
      out_drop_o  <= drop_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/keyword_hit_counter_per_line.sv
// Top level of the keyword hit counter: joins the controller and the datapath.
// Depends on khc_pkg, khc_in_if, khc_out_if, khc_ctrl and khc_dp.
//
// Each input transfer carries one request: new set, keyword character, keyword
// end, text character, line end or set end. Keywords are stored as given; text
// letters are folded to lower case and gathered into tokens. A line end gives a
// result transfer with the line's hit count and line number, a set end gives one
// with the largest line count of the set.
// A keyword request, a new set or a letter is taken in the idle state. A token
// close walks the stored keywords: it reads and checks each keyword's length,
// and where the lengths agree it reads and compares one character at a time, as
// the dictionary memory has a single read port. A line end or a set end then
// loads the result register in its own emit state.
// The result register holds a result until the receiver takes it; the block
// goes on taking requests meanwhile and waits only when a second result is due.
// Reset empties the dictionary and clears all counts; no clearing pass is needed.
module keyword_hit_counter_per_line import khc_pkg::*; #(
  parameter int unsigned MAX_KEYWORDS = DEF_MAX_KEYWORDS,
  parameter int unsigned MAX_WORD     = DEF_MAX_WORD
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  khc_in_if.sink     in_i,
  khc_out_if.source  out_o
);

  khc_cmd_t cmd;
  khc_sts_t sts;

  khc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_req_i   (in_i.req_type),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  khc_dp #(
    .MAX_KEYWORDS (MAX_KEYWORDS),
    .MAX_WORD     (MAX_WORD)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_i.req_type),
    .in_char_i   (in_i.char_code),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_kind_o  (out_o.result_kind),
    .out_count_o (out_o.hit_count),
    .out_line_o  (out_o.line_number),
    .out_drop_o  (out_o.keyword_dropped)
  );

endmodule

// File: tb/khc_checker.sv
// Checker for the keyword hit counter: watches both channels, predicts each result
// from the accepted requests and compares all its fields. Depends on khc_pkg.
module khc_checker import khc_pkg::*; #(
  parameter int unsigned MAX_KEYWORDS = DEF_MAX_KEYWORDS,
  parameter int unsigned MAX_WORD     = DEF_MAX_WORD
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [REQ_W-1:0]   in_req,
  input  logic [CHAR_W-1:0]  in_char,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_kind,
  input  logic [COUNT_W-1:0] out_count,
  input  logic [LINE_W-1:0]  out_line,
  input  logic               out_dropped,
  output int                 fail_count,
  output int                 pending,
  output int                 lines_seen,
  output int                 sets_seen
);

  typedef struct packed {
    logic               kind;
    logic [COUNT_W-1:0] count;
    logic [LINE_W-1:0]  line;
    logic               dropped;
  } tally_t;

  tally_t expected_tallies[$];

  logic [CHAR_W-1:0] dict_bytes[MAX_KEYWORDS][MAX_WORD];
  int unsigned       dict_len[MAX_KEYWORDS];
  int unsigned       n_words, word_len, tok_len;
  logic              word_long, tok_long, any_dropped;
  logic [CHAR_W-1:0] tok_bytes[MAX_WORD];
  logic [COUNT_W-1:0] hits, best;
  logic [LINE_W-1:0]  line_no;

  function automatic void clear_set();
    n_words = 0; word_len = 0; word_long = 0; tok_len = 0; tok_long = 0;
    hits = 0; best = 0; line_no = 0; any_dropped = 0;
  endfunction

  function automatic void close_token();
    logic found;
    found = 0;
    if (tok_len != 0 && !tok_long) begin
      for (int k = 0; k < n_words; k++) begin
        if (dict_len[k] == tok_len) begin
          logic same;
          same = 1;
          for (int j = 0; j < tok_len; j++)
            if (dict_bytes[k][j] != tok_bytes[j]) same = 0;
          if (same) found = 1;
        end
      end
    end
    if (found && hits != 8'hFF) hits++;
    tok_len = 0; tok_long = 0;
  endfunction

  function automatic void count_request(logic [REQ_W-1:0] req, logic [CHAR_W-1:0] c);
    tally_t t;
    case (req)
      REQ_NEW_SET: clear_set();
      REQ_KW_CHAR: begin
        if (word_len < MAX_WORD && !word_long && n_words < MAX_KEYWORDS) begin
          dict_bytes[n_words][word_len] = c;
          word_len++;
        end else if (word_len >= MAX_WORD) begin
          word_long = 1;
        end else begin
          word_len++;
        end
      end
      REQ_KW_END: begin
        if (word_len != 0 || word_long) begin
          if (word_long || n_words >= MAX_KEYWORDS) begin
            any_dropped = 1;
          end else begin
            dict_len[n_words] = word_len;
            n_words++;
          end
          word_len = 0; word_long = 0;
        end
      end
      REQ_TXT_CHAR: begin
        if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
          if (c <= "Z") c = c + 8'd32;
          if (tok_len < MAX_WORD) begin
            tok_bytes[tok_len] = c;
            tok_len++;
          end else begin
            tok_long = 1;
          end
        end else begin
          close_token();
        end
      end
      REQ_LINE_END: begin
        close_token();
        t = '{RES_LINE, hits, line_no, any_dropped};
        expected_tallies = {expected_tallies, t};
        if (hits > best) best = hits;
        if (line_no != 16'hFFFF) line_no++;
        hits = 0;
      end
      REQ_SET_END: begin
        t = '{RES_SET, best, line_no, any_dropped};
        expected_tallies = {expected_tallies, t};
        clear_set();
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tally_t want, got;
    if (!rst_ni) begin
      clear_set();
      expected_tallies.delete();
      fail_count <= 0;
      lines_seen <= 0;
      sets_seen <= 0;
      pending <= 0;
    end else begin
      if (in_valid && in_ready) count_request(in_req, in_char);
      if (out_valid && out_ready) begin
        got = '{out_kind, out_count, out_line, out_dropped};
        if (got.kind == RES_SET) sets_seen <= sets_seen + 1;
        else lines_seen <= lines_seen + 1;
        if (expected_tallies.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_tallies.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_tallies.size();
    end
  end

endmodule

// File: tb/testbench.sv
// Testbench top for the keyword hit counter: drives requests with random idling and
// stalls and gives the verdict. Depends on khc_pkg, khc_in_if, khc_out_if, khc_checker.
module testbench;
  import khc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   send_idle = 0;
  int   recv_stall = 0;
  int   sent = 0;
  int   fail_count, pending, lines_seen, sets_seen;
  string kw_pool[$];

  khc_in_if  in_ch ();
  khc_out_if out_ch ();

  keyword_hit_counter_per_line dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  khc_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_req(in_ch.req_type),
    .in_char(in_ch.char_code),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_kind(out_ch.result_kind),
    .out_count(out_ch.hit_count), .out_line(out_ch.line_number),
    .out_dropped(out_ch.keyword_dropped),
    .fail_count(fail_count), .pending(pending), .lines_seen(lines_seen),
    .sets_seen(sets_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_NEW_SET;
    in_ch.char_code = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  // One transfer; the sender may idle first. Valid stays high between items unless it idles.
  task automatic send(logic [REQ_W-1:0] req, logic [CHAR_W-1:0] c);
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.char_code <= c;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
  endtask

  task automatic send_word(logic [REQ_W-1:0] req, string w);
    for (int i = 0; i < w.len(); i++) send(req, w[i]);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [CHAR_W-1:0] text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 55) return CHAR_W'("a" + $urandom_range(5));
    if (r < 70) return CHAR_W'("A" + $urandom_range(5));
    if (r < 85) return " ";
    return CHAR_W'($urandom_range(255));
  endfunction

  task automatic random_set(int n_kw, int n_lines);
    send(REQ_NEW_SET, CHAR_W'($urandom_range(255)));
    kw_pool.delete();
    for (int k = 0; k < n_kw; k++) begin
      string w;
      int len;
      len = ($urandom_range(19) == 0) ? $urandom_range(36, 30) : $urandom_range(1, 3);
      w = "";
      for (int i = 0; i < len; i++) begin
        byte b;
        b = ($urandom_range(9) == 0) ? text_byte() : byte'("a" + $urandom_range(5));
        w = {w, string'(b)};
      end
      kw_pool = {kw_pool, w};
      send_word(REQ_KW_CHAR, w);
      if ($urandom_range(9) == 0) send(REQ_KW_END, CHAR_W'($urandom_range(255)));
      send(REQ_KW_END, CHAR_W'($urandom_range(255)));
    end
    for (int l = 0; l < n_lines; l++) begin
      int n;
      n = $urandom_range(12);
      for (int i = 0; i < n; i++) begin
        if (kw_pool.size() != 0 && $urandom_range(2) == 0) begin
          send_word(REQ_TXT_CHAR, kw_pool[$urandom_range(kw_pool.size() - 1)]);
          send(REQ_TXT_CHAR, " ");
        end else begin
          send(REQ_TXT_CHAR, text_byte());
        end
        if ($urandom_range(49) == 0)
          send(REQ_W'($urandom_range(7, 6)), CHAR_W'($urandom_range(255)));
        if ($urandom_range(59) == 0) send(REQ_KW_CHAR, "a");
      end
      send(REQ_LINE_END, CHAR_W'($urandom_range(255)));
    end
    send(REQ_SET_END, CHAR_W'($urandom_range(255)));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: duplicates, case folding, empty keyword, unused request codes.
    send(REQ_KW_END, 8'h00);
    send_word(REQ_KW_CHAR, "ab");  send(REQ_KW_END, 8'hFF);
    send_word(REQ_KW_CHAR, "ab");  send(REQ_KW_END, 8'h00);
    send_word(REQ_KW_CHAR, "Ab");  send(REQ_KW_END, 8'h00);
    send_word(REQ_TXT_CHAR, "AB"); send(REQ_TXT_CHAR, 8'hFF);
    send_word(REQ_TXT_CHAR, "ab"); send(REQ_TXT_CHAR, 8'h80);
    send(REQ_TXT_CHAR, 8'h00);     send(REQ_LINE_END, 8'h00);
    send(3'd6, 8'h55); send(3'd7, 8'hAA);
    send_word(REQ_TXT_CHAR, "zZ"); send(REQ_LINE_END, 8'hFF);
    send(REQ_SET_END, 8'h00);
    drain();

    // Long words, a full dictionary and saturating hit count.
    for (int i = 0; i < 34; i++) send(REQ_KW_CHAR, "q");
    send(REQ_KW_END, 8'h00);
    for (int i = 0; i < 33; i++) send(REQ_TXT_CHAR, "q");
    send(REQ_LINE_END, 8'h00);
    for (int k = 0; k < 33; k++) begin
      send(REQ_KW_CHAR, CHAR_W'("a" + (k % 26))); send(REQ_KW_CHAR, CHAR_W'("a" + k / 26));
      send(REQ_KW_END, 8'h00);
    end
    for (int i = 0; i < 260; i++) begin
      send(REQ_TXT_CHAR, "a"); send(REQ_TXT_CHAR, "a"); send(REQ_TXT_CHAR, " ");
    end
    send(REQ_LINE_END, 8'h00);
    send(REQ_SET_END, 8'h00);
    drain();

    for (int p = 0; p < 4; p++) begin
      int base;
      send_idle = (p == 1 || p == 3) ? ((p == 1) ? 82 : 36) : 0;
      recv_stall = (p == 2) ? 82 : ((p == 3) ? 36 : 0);
      base = sent;
      while (sent - base < 140) random_set($urandom_range(0, 6), $urandom_range(1, 5));
      drain();
    end

    $display("Sent %0d requests; checked %0d line counts and %0d set maxima.",
             sent, lines_seen, sets_seen);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/khc_pkg.sv
rtl/khc_in_if.sv
rtl/khc_out_if.sv
rtl/khc_ram.sv
rtl/khc_ctrl.sv
rtl/khc_dp.sv
rtl/keyword_hit_counter_per_line.sv
tb/khc_checker.sv
tb/testbench.sv
